[rtl/bbsl_pkg.sv]
// shared types and constants for the button bank selector with lockout
package bbsl_pkg;

  localparam int unsigned NUM_BANKS_DEF = 8;
  localparam int unsigned BANK_W = 3;
  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] LOCK_PERIOD_RST = 16'd781;

  // segment bits 0..6 = a,b,c,d,e,g,f, pattern for digit bank+1
  localparam logic [6:0] SEG_TABLE [8] = '{
    7'h06, 7'h3B, 7'h2F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F
  };

  typedef struct packed {
    logic next_pressed;
    logic back_pressed;
  } in_item_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank_select;
    logic              target_run;
    logic [6:0]        segment_code;
    logic              dot_on;
    logic              keys_locked;
  } out_item_t;

endpackage

[rtl/bbsl_ctrl.sv]
// bank index, lockout timer and flag state with the per-item update
module bbsl_ctrl #(
  parameter int unsigned NUM_BANKS = bbsl_pkg::NUM_BANKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  bbsl_pkg::in_item_t                 item,
  input  logic [bbsl_pkg::PERIOD_W-1:0]      lock_period,
  output bbsl_pkg::out_item_t                res
);

  localparam logic [bbsl_pkg::BANK_W-1:0] LAST_BANK = bbsl_pkg::BANK_W'(NUM_BANKS - 1);
  localparam logic [bbsl_pkg::BANK_W-1:0] BANK_LIM  = bbsl_pkg::BANK_W'(NUM_BANKS - 1);

  logic [bbsl_pkg::BANK_W-1:0]   bank_r, bank_nxt;
  logic                          lock_r, lock_nxt;
  logic [bbsl_pkg::PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic                          running_r, running_nxt;
  logic                          run_r, run_nxt;
  logic                          dot_r, dot_nxt;
  logic                          do_next, do_back;

  assign do_next = !lock_r && item.next_pressed;
  assign do_back = !lock_r && item.back_pressed;

  always_comb begin
    bank_nxt    = bank_r;
    lock_nxt    = lock_r;
    cnt_nxt     = cnt_r;
    running_nxt = running_r;
    run_nxt     = run_r;
    dot_nxt     = dot_r;
    priority if (do_next || do_back) begin
      if (do_next) begin
        bank_nxt = (bank_r >= BANK_LIM) ? '0 : bank_r + 1'b1;
      end else begin
        bank_nxt = (bank_r == '0 || bank_r > BANK_LIM) ? LAST_BANK : bank_r - 1'b1;
      end
      lock_nxt    = 1'b1;
      run_nxt     = 1'b0;
      dot_nxt     = 1'b1;
      cnt_nxt     = '0;
      running_nxt = 1'b1;
    end else if (running_r) begin
      if (cnt_r >= lock_period) begin
        // timer expired
        run_nxt = 1'b1;
        dot_nxt = 1'b0;
        cnt_nxt = '0;
        if (!item.next_pressed && !item.back_pressed) begin
          lock_nxt    = 1'b0;
          running_nxt = 1'b0;
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= '0;
      lock_r    <= 1'b1;
      cnt_r     <= '0;
      running_r <= 1'b1;
      run_r     <= 1'b0;
      dot_r     <= 1'b1;
    end else if (step) begin
      bank_r    <= bank_nxt;
      lock_r    <= lock_nxt;
      cnt_r     <= cnt_nxt;
      running_r <= running_nxt;
      run_r     <= run_nxt;
      dot_r     <= dot_nxt;
    end
  end

  always_comb begin
    res.bank_select  = bank_nxt;
    res.target_run   = run_nxt;
    res.segment_code = (bank_nxt > BANK_LIM) ? bbsl_pkg::SEG_TABLE[0]
                                             : bbsl_pkg::SEG_TABLE[bank_nxt];
    res.dot_on       = dot_nxt;
    res.keys_locked  = lock_nxt;
  end

endmodule

[rtl/button_bank_selector_with_lockout_core.sv]
// top level: input register, state update and result register of the bank selector
// an item waits in the input register until the state update loads its result register
// throughput: one item per cycle while out_ready is high, set by the single state update
// out_ready low holds the result register; one more item waits in the input register
// reset: synchronous active-low rst_n; bank 0, keys locked, lockout timer running,
// target held, dot lit, lock_period 781
module button_bank_selector_with_lockout_core #(
  parameter int unsigned NUM_BANKS = bbsl_pkg::NUM_BANKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bbsl_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bbsl_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [bbsl_pkg::PERIOD_W-1:0] cfg_wr_data
);

  logic [bbsl_pkg::PERIOD_W-1:0] period_r;
  logic                          in_vld_r;
  bbsl_pkg::in_item_t            in_data_r;
  logic                          out_vld_r;
  bbsl_pkg::out_item_t           out_data_r;
  bbsl_pkg::out_item_t           res;
  logic                          adv;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bbsl_pkg::LOCK_PERIOD_RST;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  bbsl_ctrl #(
    .NUM_BANKS (NUM_BANKS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .item        (in_data_r),
    .lock_period (period_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_unlocked_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r.keys_locked) |-> (out_data_r.target_run && !out_data_r.dot_on))
    else $error("keys unlocked while target held or dot lit");

  a_dot_vs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r.dot_on != out_data_r.target_run))
    else $error("dot and run flag not complementary");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_adv_loads: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result lost after state update");

endmodule
